// ===== src/integer_scale_pixel_mapper_unit_macros.svh =====
// Assertion macros shared by the checker.
`ifndef INTEGER_SCALE_PIXEL_MAPPER_UNIT_MACROS_SVH
`define INTEGER_SCALE_PIXEL_MAPPER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ISPM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define ISPM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ispm_pkg.sv =====
// ----------------------------------------------------------------------------
// ispm_pkg
// Shared types and constants of the integer scale pixel mapper.
// ----------------------------------------------------------------------------
package ispm_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int IDX_W          = 8;

    localparam logic [IDX_W-1:0] REG_VIRT_W = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_VIRT_H = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_OUT_W  = IDX_W'(2);
    localparam logic [IDX_W-1:0] REG_OUT_H  = IDX_W'(3);

    localparam int RST_VIRT_W = 320;
    localparam int RST_VIRT_H = 180;
    localparam int RST_OUT_W  = 1920;
    localparam int RST_OUT_H  = 1080;

    localparam logic [2:0] ST_VIRT_ZERO  = 3'd0;
    localparam logic [2:0] ST_OUT_ZERO   = 3'd1;
    localparam logic [2:0] ST_UNDERSIZED = 3'd2;
    localparam logic [2:0] ST_LETTERBOX  = 3'd3;
    localparam logic [2:0] ST_EXACT      = 3'd4;

    typedef struct packed {
        logic [15:0] phys_x;
        logic [15:0] phys_y;
    } pix_in_t;

    typedef struct packed {
        logic [2:0]  plan_status;
        logic [15:0] scale_factor;
        logic [15:0] content_left;
        logic [15:0] content_top;
        logic [15:0] content_span_x;
        logic [15:0] content_span_y;
        logic [15:0] margin_right;
        logic [15:0] margin_bottom;
        logic        hit_output;
        logic        hit_content;
        logic [15:0] source_x;
        logic [15:0] source_y;
    } pix_out_t;

    typedef enum logic [4:0] {
        PL_IDLE = 5'b00001,
        PL_LOAD = 5'b00010,
        PL_DIV  = 5'b00100,
        PL_MUL  = 5'b01000,
        PL_FIN  = 5'b10000
    } plan_state_t;

endpackage

// ===== src/integer_scale_pixel_mapper_unit.sv =====
// ----------------------------------------------------------------------------
// integer_scale_pixel_mapper_unit
// Maps physical output pixels to virtual image pixels under an integer-scale,
// centered letterbox or crop plan.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_we/cfg_index/cfg_data write the four extents (virtual w/h, output
//   w/h). Each write to a known index restarts plan derivation; unknown
//   indexes are ignored. Derivation loads the extents, forms one quotient
//   bit per cycle in the plan sequencer, then takes the min, multiplies and
//   finishes; in_stall is held high meanwhile.
//   After reset the same pass runs on the reset extents (320x180 onto
//   1920x1080), so in_stall is high until that pass has finished.
//   Input beats carry phys_x/phys_y; each gives one output beat with the
//   plan fields, the hit flags and the mapped source coordinate.
//   Throughput: one beat per cycle while in_stall is low. The pipeline
//   has COORD_BITS+2 register stages: the offset stage, one divider
//   stage per quotient bit, the output stage.
//   When out_stall is high while out_valid is up, the whole pipeline holds
//   and in_stall rises; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module integer_scale_pixel_mapper_unit #(
    parameter int COORD_BITS = ispm_pkg::COORD_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  ispm_pkg::pix_in_t          in_data,
    output logic                       out_valid,
    input  logic                       out_stall,
    output ispm_pkg::pix_out_t         out_data,
    input  logic                       cfg_we,
    input  logic [ispm_pkg::IDX_W-1:0] cfg_index,
    input  logic [COORD_BITS-1:0]      cfg_data
);
    import ispm_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int EW = (CB > 16) ? CB : 16;   // common width for pixel compares

    // configuration registers
    logic [CB-1:0] vw_reg, vh_reg, ow_reg, oh_reg;
    logic          cfg_hit;

    always_comb
    begin
        case (cfg_index)
            REG_VIRT_W, REG_VIRT_H, REG_OUT_W, REG_OUT_H: cfg_hit = cfg_we;
            default:                                      cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vw_reg <= CB'(RST_VIRT_W);
            vh_reg <= CB'(RST_VIRT_H);
            ow_reg <= CB'(RST_OUT_W);
            oh_reg <= CB'(RST_OUT_H);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_VIRT_W: vw_reg <= cfg_data;
                REG_VIRT_H: vh_reg <= cfg_data;
                REG_OUT_W:  ow_reg <= cfg_data;
                REG_OUT_H:  oh_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // plan
    logic          busy;
    logic [2:0]    p_status;
    logic [CB-1:0] p_scale, p_orgx, p_orgy, p_sizx, p_sizy;
    logic [CB-1:0] p_crpx, p_crpy, p_marr, p_marb;
    logic          plan_ok;

    ispm_plan #(
        .CB(CB)
    ) u_plan (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cfg_hit),
        .vw     (vw_reg),
        .vh     (vh_reg),
        .ow     (ow_reg),
        .oh     (oh_reg),
        .busy   (busy),
        .status (p_status),
        .scale  (p_scale),
        .org_x  (p_orgx),
        .org_y  (p_orgy),
        .size_x (p_sizx),
        .size_y (p_sizy),
        .crop_x (p_crpx),
        .crop_y (p_crpy),
        .mar_r  (p_marr),
        .mar_b  (p_marb)
    );

    always_comb
    begin
        case (p_status) inside
            ST_UNDERSIZED, ST_LETTERBOX, ST_EXACT: plan_ok = (p_scale != '0);
            default:                               plan_ok = 1'b0;
        endcase
    end

    // pipeline advance: freeze everything while the output beat is held
    logic en;
    assign en       = !(out_valid && out_stall);
    assign in_stall = busy || !en;

    // stage 0: window tests and offsets into the content rectangle
    logic          v0_reg;
    logic          io0_reg, ir0_reg;
    logic [CB-1:0] offx0_reg, offy0_reg;
    logic          io0_next, ir0_next;
    logic [EW-1:0] px_e, py_e, offx_e, offy_e;

    always_comb
    begin
        logic [EW:0] endx, endy;
        px_e     = EW'(in_data.phys_x);
        py_e     = EW'(in_data.phys_y);
        endx     = (EW+1)'(p_orgx) + (EW+1)'(p_sizx);
        endy     = (EW+1)'(p_orgy) + (EW+1)'(p_sizy);
        io0_next = plan_ok && (px_e < EW'(ow_reg)) && (py_e < EW'(oh_reg));
        ir0_next = io0_next
                   && (px_e >= EW'(p_orgx)) && ((EW+1)'(px_e) < endx)
                   && (py_e >= EW'(p_orgy)) && ((EW+1)'(py_e) < endy);
        offx_e   = px_e - EW'(p_orgx);
        offy_e   = py_e - EW'(p_orgy);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (en)
            v0_reg <= in_valid && !busy;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            io0_reg   <= io0_next;
            ir0_reg   <= ir0_next;
            offx0_reg <= offx_e[CB-1:0];
            offy0_reg <= offy_e[CB-1:0];
        end
    end

    // divider stages: offset / scale, flags travel alongside
    logic [CB-1:0] qx, qy;
    logic          vd_reg [CB];
    logic          iod_reg [CB];
    logic          ird_reg [CB];

    ispm_div_pipe #(.W(CB)) u_div_x (
        .clk (clk),
        .en  (en),
        .num (offx0_reg),
        .den (p_scale),
        .quo (qx)
    );

    ispm_div_pipe #(.W(CB)) u_div_y (
        .clk (clk),
        .en  (en),
        .num (offy0_reg),
        .den (p_scale),
        .quo (qy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < CB; k++)
                vd_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            vd_reg[0] <= v0_reg;
            for (int k = 1; k < CB; k++)
                vd_reg[k] <= vd_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            iod_reg[0] <= io0_reg;
            ird_reg[0] <= ir0_reg;
            for (int k = 1; k < CB; k++)
            begin
                iod_reg[k] <= iod_reg[k-1];
                ird_reg[k] <= ird_reg[k-1];
            end
        end
    end

    // output stage: add crop origin, final bounds check
    logic     out_valid_reg;
    pix_out_t out_data_reg, out_data_next;

    always_comb
    begin
        logic [CB:0] vx, vy;
        logic        con;
        vx  = {1'b0, p_crpx} + {1'b0, qx};
        vy  = {1'b0, p_crpy} + {1'b0, qy};
        con = ird_reg[CB-1] && (vx < {1'b0, vw_reg}) && (vy < {1'b0, vh_reg});
        out_data_next.plan_status    = p_status;
        out_data_next.scale_factor   = 16'(p_scale);
        out_data_next.content_left   = 16'(p_orgx);
        out_data_next.content_top    = 16'(p_orgy);
        out_data_next.content_span_x = 16'(p_sizx);
        out_data_next.content_span_y = 16'(p_sizy);
        out_data_next.margin_right   = 16'(p_marr);
        out_data_next.margin_bottom  = 16'(p_marb);
        out_data_next.hit_output     = iod_reg[CB-1];
        out_data_next.hit_content    = con;
        out_data_next.source_x       = con ? 16'(vx[CB-1:0]) : 16'd0;
        out_data_next.source_y       = con ? 16'(vy[CB-1:0]) : 16'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= vd_reg[CB-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== src/ispm_div_pipe.sv =====
// ----------------------------------------------------------------------------
// ispm_div_pipe
// Pipelined restoring divider, one quotient bit per stage, W stages.
// ----------------------------------------------------------------------------
module ispm_div_pipe #(
    parameter int W = 16
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] num,
    input  logic [W-1:0] den,
    output logic [W-1:0] quo
);
    // {remainder, dividend/quotient} per stage
    logic [2*W-1:0] acc_reg  [W];
    logic [2*W-1:0] acc_next [W];

    always_comb
    begin
        logic [2*W:0] t;
        logic [W:0]   hi;
        logic         qb;
        for (int k = 0; k < W; k++)
        begin
            if (k == 0)
                t = {{W{1'b0}}, num, 1'b0};
            else
                t = {acc_reg[(k == 0) ? 0 : k-1], 1'b0};
            hi = t[2*W:W];
            qb = (hi >= {1'b0, den});
            if (qb)
                hi = hi - {1'b0, den};
            acc_next[k] = {hi[W-1:0], t[W-1:1], qb};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < W; k++)
                acc_reg[k] <= acc_next[k];
        end
    end

    assign quo = acc_reg[W-1][W-1:0];

endmodule

// ===== src/ispm_plan.sv =====
// ----------------------------------------------------------------------------
// ispm_plan
// Plan sequencer: derives scale, content rectangle, crop and margins.
// ----------------------------------------------------------------------------
module ispm_plan #(
    parameter int CB = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [CB-1:0] vw,
    input  logic [CB-1:0] vh,
    input  logic [CB-1:0] ow,
    input  logic [CB-1:0] oh,
    output logic          busy,
    output logic [2:0]    status,
    output logic [CB-1:0] scale,
    output logic [CB-1:0] org_x,
    output logic [CB-1:0] org_y,
    output logic [CB-1:0] size_x,
    output logic [CB-1:0] size_y,
    output logic [CB-1:0] crop_x,
    output logic [CB-1:0] crop_y,
    output logic [CB-1:0] mar_r,
    output logic [CB-1:0] mar_b
);
    import ispm_pkg::*;

    localparam int CNT_W = $clog2(CB);

    plan_state_t      state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CB:0]      rx_reg, rx_next, ry_reg, ry_next;   // partial remainders
    logic [CB-1:0]    qx_reg, qx_next, qy_reg, qy_next;   // dividend / quotient
    logic [CB-1:0]    sc_reg, sc_next;
    logic [CB-1:0]    mx_reg, mx_next, my_reg, my_next;   // scaled sizes

    logic [2:0]       status_reg, status_next;
    logic [CB-1:0]    scale_reg, scale_next;
    logic [CB-1:0]    orgx_reg, orgx_next, orgy_reg, orgy_next;
    logic [CB-1:0]    sizx_reg, sizx_next, sizy_reg, sizy_next;
    logic [CB-1:0]    crpx_reg, crpx_next, crpy_reg, crpy_next;
    logic [CB-1:0]    marr_reg, marr_next, marb_reg, marb_next;

    always_comb
    begin
        logic [CB:0]    tx, ty;
        logic [2*CB-1:0] px, py;
        logic [CB-1:0]  sw, sh, rw, rh;
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        rx_next     = rx_reg;
        ry_next     = ry_reg;
        qx_next     = qx_reg;
        qy_next     = qy_reg;
        sc_next     = sc_reg;
        mx_next     = mx_reg;
        my_next     = my_reg;
        status_next = status_reg;
        scale_next  = scale_reg;
        orgx_next   = orgx_reg;
        orgy_next   = orgy_reg;
        sizx_next   = sizx_reg;
        sizy_next   = sizy_reg;
        crpx_next   = crpx_reg;
        crpy_next   = crpy_reg;
        marr_next   = marr_reg;
        marb_next   = marb_reg;
        tx = '0;
        ty = '0;
        px = '0;
        py = '0;
        sw = '0;
        sh = '0;
        rw = '0;
        rh = '0;
        case (state_reg)
            PL_LOAD:
            begin
                rx_next    = '0;
                ry_next    = '0;
                qx_next    = ow;
                qy_next    = oh;
                cnt_next   = '0;
                state_next = PL_DIV;
            end
            PL_DIV:
            begin
                tx = {rx_reg[CB-1:0], qx_reg[CB-1]};
                ty = {ry_reg[CB-1:0], qy_reg[CB-1]};
                if (tx >= {1'b0, vw})
                begin
                    rx_next = tx - {1'b0, vw};
                    qx_next = {qx_reg[CB-2:0], 1'b1};
                end
                else
                begin
                    rx_next = tx;
                    qx_next = {qx_reg[CB-2:0], 1'b0};
                end
                if (ty >= {1'b0, vh})
                begin
                    ry_next = ty - {1'b0, vh};
                    qy_next = {qy_reg[CB-2:0], 1'b1};
                end
                else
                begin
                    ry_next = ty;
                    qy_next = {qy_reg[CB-2:0], 1'b0};
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(CB-1))
                    state_next = PL_MUL;
            end
            PL_MUL:
            begin
                // min of the axis quotients, then size = extent * scale
                sc_next = (qx_reg < qy_reg) ? qx_reg : qy_reg;
                px = (2*CB)'(vw) * (2*CB)'(sc_next);
                py = (2*CB)'(vh) * (2*CB)'(sc_next);
                mx_next = px[CB-1:0];
                my_next = py[CB-1:0];
                state_next = PL_FIN;
            end
            PL_FIN:
            begin
                status_next = ST_EXACT;
                scale_next  = '0;
                orgx_next   = '0;
                orgy_next   = '0;
                sizx_next   = '0;
                sizy_next   = '0;
                crpx_next   = '0;
                crpy_next   = '0;
                marr_next   = '0;
                marb_next   = '0;
                if (vw == '0 || vh == '0)
                    status_next = ST_VIRT_ZERO;
                else if (ow == '0 || oh == '0)
                    status_next = ST_OUT_ZERO;
                else if (ow < vw || oh < vh)
                begin
                    sw          = (vw < ow) ? vw : ow;
                    sh          = (vh < oh) ? vh : oh;
                    status_next = ST_UNDERSIZED;
                    scale_next  = CB'(1);
                    crpx_next   = (vw - sw) >> 1;
                    crpy_next   = (vh - sh) >> 1;
                    sizx_next   = sw;
                    sizy_next   = sh;
                    rw          = ow - sw;
                    rh          = oh - sh;
                    orgx_next   = rw >> 1;
                    orgy_next   = rh >> 1;
                    marr_next   = rw - (rw >> 1);
                    marb_next   = rh - (rh >> 1);
                end
                else
                begin
                    rw          = ow - mx_reg;
                    rh          = oh - my_reg;
                    scale_next  = sc_reg;
                    sizx_next   = mx_reg;
                    sizy_next   = my_reg;
                    orgx_next   = rw >> 1;
                    orgy_next   = rh >> 1;
                    marr_next   = rw - (rw >> 1);
                    marb_next   = rh - (rh >> 1);
                    status_next = (rw != '0 || rh != '0) ? ST_LETTERBOX : ST_EXACT;
                end
                state_next = PL_IDLE;
            end
            default:
                state_next = PL_IDLE;
        endcase
        if (start)
            state_next = PL_LOAD;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PL_LOAD;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rx_reg     <= rx_next;
        ry_reg     <= ry_next;
        qx_reg     <= qx_next;
        qy_reg     <= qy_next;
        sc_reg     <= sc_next;
        mx_reg     <= mx_next;
        my_reg     <= my_next;
        status_reg <= status_next;
        scale_reg  <= scale_next;
        orgx_reg   <= orgx_next;
        orgy_reg   <= orgy_next;
        sizx_reg   <= sizx_next;
        sizy_reg   <= sizy_next;
        crpx_reg   <= crpx_next;
        crpy_reg   <= crpy_next;
        marr_reg   <= marr_next;
        marb_reg   <= marb_next;
    end

    assign busy   = (state_reg != PL_IDLE);
    assign status = status_reg;
    assign scale  = scale_reg;
    assign org_x  = orgx_reg;
    assign org_y  = orgy_reg;
    assign size_x = sizx_reg;
    assign size_y = sizy_reg;
    assign crop_x = crpx_reg;
    assign crop_y = crpy_reg;
    assign mar_r  = marr_reg;
    assign mar_b  = marb_reg;

endmodule

// ===== src/ispm_checker.sv =====
// ----------------------------------------------------------------------------
// ispm_checker
// Port-level checks for the pixel mapper, bound to the top level.
// ----------------------------------------------------------------------------
`include "integer_scale_pixel_mapper_unit_macros.svh"

module ispm_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_stall,
    input ispm_pkg::pix_out_t out_data
);
    import ispm_pkg::*;

    logic bad_plan;
    assign bad_plan = (out_data.plan_status == ST_VIRT_ZERO)
                      || (out_data.plan_status == ST_OUT_ZERO);

    `ISPM_ASSERT_NEXT(a_hold_valid, out_valid && out_stall, out_valid, "held beat dropped")
    `ISPM_ASSERT_NEXT(a_hold_data, out_valid && out_stall, $stable(out_data), "held beat changed")
    `ISPM_ASSERT_NOW(a_con_in_out, out_valid && out_data.hit_content, out_data.hit_output, "content off output")
    `ISPM_ASSERT_NOW(a_src_zero, out_valid && !out_data.hit_content, out_data.source_x == 16'd0 && out_data.source_y == 16'd0, "source not zero")
    `ISPM_ASSERT_NOW(a_bad_plan, out_valid && bad_plan, out_data.scale_factor == 16'd0 && !out_data.hit_output, "invalid plan fields")

endmodule

bind integer_scale_pixel_mapper_unit ispm_checker u_ispm_checker (.*);
